FILE: sv/pfs_pkg.sv
// Shared types and constants for the panel fault supervisor.
package pfs_pkg;

    localparam int HISTORY_DEPTH = 4;
    localparam int TIME_BITS     = 32;
    localparam int WINDOW_BITS   = 20;
    localparam int COUNT_BITS    = 4;

    localparam logic [COUNT_BITS-1:0] RETRY_SAT = '1;

    typedef enum logic [2:0] {
        OP_MODE_CHECK = 3'd0,
        OP_ON_CHECK   = 3'd1,
        OP_DETECT     = 3'd2,
        OP_LINK       = 3'd3,
        OP_EXT_FAIL   = 3'd4,
        OP_ON         = 3'd5,
        OP_OFF        = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_READ_ERR  = 2'd1,
        ST_STATE_ERR = 2'd2,
        ST_LINE      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_RETRY_LIMIT      = 3'd0,
        CFG_FAULT_WINDOW     = 3'd1,
        CFG_WINDOW_SETS_OVER = 3'd2,
        CFG_DETECT_PRESENT   = 3'd3,
        CFG_LINK_PRESENT     = 3'd4,
        CFG_POWER_MODE_MASK  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  retry_limit;
        logic [WINDOW_BITS-1:0] fault_window_ms;
        logic                   window_sets_retry_over;
        logic                   detect_line_present;
        logic                   link_error_line_present;
        logic [7:0]             power_mode_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           operation;
        logic                 read_ok;
        logic [7:0]           power_mode;
        logic                 detect_level;
        logic                 link_error_level;
        logic                 recovery_pending;
        logic [TIME_BITS-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]            check_result;
        logic                  recovery_request;
        logic                  panel_off_event;
        logic                  retry_over_flag;
        logic                  irq_reenable;
        logic                  link_clear;
        logic                  backlight_off;
        logic [COUNT_BITS-1:0] retry_count;
    } result_t;

    typedef struct packed {
        logic                  panel_is_on;
        status_t               mode_status;
        logic [COUNT_BITS-1:0] retry_counter;
        logic                  over_limit;
    } sup_state_t;

endpackage

FILE: sv/pfs_cfg_regs.sv
// Configuration register file of the panel fault supervisor.
module pfs_cfg_regs
    import pfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [2:0]             wr_index,
    input  logic [WINDOW_BITS-1:0] wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_RETRY_LIMIT:      cfg_next.retry_limit = wr_data[COUNT_BITS-1:0];
                CFG_FAULT_WINDOW:     cfg_next.fault_window_ms = wr_data;
                CFG_WINDOW_SETS_OVER: cfg_next.window_sets_retry_over = wr_data[0];
                CFG_DETECT_PRESENT:   cfg_next.detect_line_present = wr_data[0];
                CFG_LINK_PRESENT:     cfg_next.link_error_line_present = wr_data[0];
                CFG_POWER_MODE_MASK:  cfg_next.power_mode_mask = wr_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit             <= COUNT_BITS'(3);
            cfg_reg.fault_window_ms         <= WINDOW_BITS'(10000);
            cfg_reg.window_sets_retry_over  <= 1'b1;
            cfg_reg.detect_line_present     <= 1'b1;
            cfg_reg.link_error_line_present <= 1'b1;
            cfg_reg.power_mode_mask         <= 8'h14;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/pfs_history.sv
// Detect-fault time history and burst window compare.
module pfs_history
    import pfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   record,
    input  logic [TIME_BITS-1:0]   now,
    input  logic [WINDOW_BITS-1:0] window,
    output logic                   window_hit
);

    logic [TIME_BITS-1:0]     times_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [TIME_BITS-1:0]     diff;

    // difference wraps modulo the time width
    assign diff       = now - times_reg[HISTORY_DEPTH-1];
    assign window_hit = valid_reg[HISTORY_DEPTH-1] &&
                        (diff <= {{(TIME_BITS-WINDOW_BITS){1'b0}}, window});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (record)
        begin
            if (window_hit)
            begin
                valid_reg <= '0;
            end
            else
            begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
                valid_reg[0] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (record && !window_hit)
        begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            begin
                times_reg[i] <= times_reg[i-1];
            end
            times_reg[0] <= now;
        end
    end

endmodule

FILE: sv/pfs_eval.sv
// Per-event decision logic: result fields and next supervisor state.
module pfs_eval
    import pfs_pkg::*;
(
    input  item_t      item,
    input  cfg_t       cfg,
    input  sup_state_t st,
    input  logic       window_hit,
    output sup_state_t st_next,
    output result_t    res,
    output logic       record
);

    logic    detect_fault;
    logic    link_fault;
    logic    req;
    logic    reenable;
    logic    lclear;
    logic    bl_off;
    status_t status;
    status_t mode_eval;

    assign detect_fault = cfg.detect_line_present && !item.detect_level;
    assign link_fault   = cfg.link_error_line_present && item.link_error_level;

    always_comb
    begin
        if (!item.read_ok)
            mode_eval = ST_READ_ERR;
        else if ((item.power_mode & cfg.power_mode_mask) != cfg.power_mode_mask)
            mode_eval = ST_STATE_ERR;
        else
            mode_eval = ST_OK;
    end

    always_comb
    begin
        st_next  = st;
        status   = ST_OK;
        req      = 1'b0;
        reenable = 1'b0;
        lclear   = 1'b0;
        bl_off   = 1'b0;
        record   = 1'b0;
        case (op_t'(item.operation))
            OP_MODE_CHECK:
            begin
                if (!st.panel_is_on)
                begin
                    st_next.mode_status = mode_eval;
                    status              = mode_eval;
                end
            end
            OP_ON_CHECK:
            begin
                if (st.mode_status == ST_READ_ERR || st.mode_status == ST_STATE_ERR)
                    status = st.mode_status;
                if (detect_fault || link_fault)
                    status = ST_LINE;
                if (status != ST_OK)
                begin
                    if (st.retry_counter >= cfg.retry_limit)
                        st_next.over_limit = 1'b1;
                    if (st.retry_counter != RETRY_SAT)
                        st_next.retry_counter = st.retry_counter + 1'b1;
                    req = st.panel_is_on && !item.recovery_pending;
                end
                else
                begin
                    st_next.retry_counter = '0;
                    st_next.over_limit    = 1'b0;
                end
            end
            OP_DETECT:
            begin
                if (st.panel_is_on && !item.recovery_pending)
                begin
                    if (detect_fault)
                    begin
                        status = ST_LINE;
                        record = 1'b1;
                        req    = 1'b1;
                        if (window_hit && cfg.window_sets_retry_over)
                            st_next.over_limit = 1'b1;
                    end
                    else
                    begin
                        reenable = 1'b1;
                    end
                end
            end
            OP_LINK:
            begin
                if (st.panel_is_on && !item.recovery_pending)
                begin
                    if (link_fault)
                    begin
                        status = ST_LINE;
                        lclear = 1'b1;
                        req    = 1'b1;
                    end
                    else
                    begin
                        reenable = 1'b1;
                    end
                end
            end
            OP_EXT_FAIL:
            begin
                req = 1'b1;
            end
            OP_ON:
            begin
                st_next.panel_is_on = 1'b1;
            end
            OP_OFF:
            begin
                st_next.panel_is_on = 1'b0;
                bl_off              = st.over_limit;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    always_comb
    begin
        res.check_result     = status;
        res.recovery_request = req;
        res.panel_off_event  = req && st_next.over_limit;
        res.retry_over_flag  = st_next.over_limit;
        res.irq_reenable     = reenable;
        res.link_clear       = lclear;
        res.backlight_off    = bl_off;
        res.retry_count      = st_next.retry_counter;
    end

endmodule

FILE: sv/panel_fault_supervisor_core.sv
// Top level of the panel fault supervisor: input stage, decision, result stage.
//
//  channel  | signals                          | direction | beat
//  ---------+----------------------------------+-----------+-----------------------------
//  s_axis   | tvalid, tready, tdata[47:0]      | in        | one event
//  m_axis   | tvalid, tready, tdata[15:0]      | out       | one result per event
//  cfg      | valid, ready, index[2:0], data   | in        | one register write
//
//  One event per cycle sustained while m_axis_tready is high.
//  The decision is one combinational pass between the input and result registers;
//  supervisor state updates as an event moves to the result register.
//  rst_n clears state, history valid bits and both stages; registers take reset values.
//  A stalled output holds the result and backpressure reaches s_axis_tready the same cycle.
//  cfg_ready is always high.
module panel_fault_supervisor_core
    import pfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation[2:0], read_ok[3], power_mode[11:4], detect_level[12],
    // link_error_level[13], recovery_pending[14], time_ms[46:15], zero[47]
    input  logic [47:0]            s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // check_result[1:0], recovery_request[2], panel_off_event[3], retry_over_flag[4],
    // irq_reenable[5], link_clear[6], backlight_off[7], retry_count[11:8], zero[15:12]
    output logic [15:0]            m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [WINDOW_BITS-1:0] cfg_data
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    item_t      in_item_next;
    logic       out_valid_reg;
    result_t    out_res_reg;
    sup_state_t state_reg;
    sup_state_t state_next;
    result_t    res;
    cfg_t       cfg;
    logic       advance;
    logic       fire;
    logic       record;
    logic       window_hit;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_item_next.operation        = s_axis_tdata[2:0];
        in_item_next.read_ok          = s_axis_tdata[3];
        in_item_next.power_mode       = s_axis_tdata[11:4];
        in_item_next.detect_level     = s_axis_tdata[12];
        in_item_next.link_error_level = s_axis_tdata[13];
        in_item_next.recovery_pending = s_axis_tdata[14];
        in_item_next.time_ms          = s_axis_tdata[46:15];
    end

    pfs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pfs_history u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .record     (record && fire),
        .now        (in_item_reg.time_ms),
        .window     (cfg.fault_window_ms),
        .window_hit (window_hit)
    );

    pfs_eval u_eval (
        .item       (in_item_reg),
        .cfg        (cfg),
        .st         (state_reg),
        .window_hit (window_hit),
        .st_next    (state_next),
        .res        (res),
        .record     (record)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{panel_is_on: 1'b0, mode_status: ST_OK,
                               retry_counter: '0, over_limit: 1'b0};
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_item_next;
        if (fire)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_res_reg.retry_count, out_res_reg.backlight_off,
                            out_res_reg.link_clear, out_res_reg.irq_reenable,
                            out_res_reg.retry_over_flag, out_res_reg.panel_off_event,
                            out_res_reg.recovery_request, out_res_reg.check_result};

    // a panel-off event only goes out with a recovery request under retry-over
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.panel_off_event) |->
            (out_res_reg.recovery_request && out_res_reg.retry_over_flag))
        else $error("panel_off_event without request and retry-over");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.backlight_off) |-> out_res_reg.retry_over_flag)
        else $error("backlight_off without retry-over");

    // an event in the input stage moves on when the result stage is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input stage did not advance into free result stage");

    // state only changes when an event is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("supervisor state changed without an event");

endmodule

FILE: dv/panel_supervisor_monitor.sv
// Watches the supervisor's event, result and register channels, predicts each result and compares.
module panel_supervisor_monitor
    import pfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [47:0]            s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [15:0]            m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [WINDOW_BITS-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_BITS-1:0]  RESET_RETRY_LIMIT = 4'd3;
    localparam logic [WINDOW_BITS-1:0] RESET_WINDOW_MS   = 20'd10000;
    localparam logic [7:0]             RESET_MODE_MASK   = 8'h14;

    cfg_t                 regs;
    sup_state_t           sup;
    logic [TIME_BITS-1:0] fault_stamp [HISTORY_DEPTH];
    logic                 fault_stamp_valid [HISTORY_DEPTH];
    result_t              results_due [$];
    result_t              due;
    result_t              seen;
    item_t                ev;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(string what, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Applies one event to the supervisor state and returns the result it should produce.
    function automatic result_t predict_panel_event(item_t e);
        result_t              r;
        status_t              verdict;
        logic                 det_fault;
        logic                 link_fault;
        logic [TIME_BITS-1:0] age;
        r          = '0;
        verdict    = ST_OK;
        det_fault  = regs.detect_line_present && !e.detect_level;
        link_fault = regs.link_error_line_present && e.link_error_level;
        case (e.operation)
            OP_MODE_CHECK:
                // status byte is only read while the panel is off
                if (!sup.panel_is_on)
                begin
                    if (!e.read_ok)
                        sup.mode_status = ST_READ_ERR;
                    else if ((e.power_mode & regs.power_mode_mask) != regs.power_mode_mask)
                        sup.mode_status = ST_STATE_ERR;
                    else
                        sup.mode_status = ST_OK;
                    verdict = sup.mode_status;
                end
            OP_ON_CHECK:
            begin
                if (sup.mode_status == ST_READ_ERR || sup.mode_status == ST_STATE_ERR)
                    verdict = sup.mode_status;
                if (det_fault || link_fault)
                    verdict = ST_LINE;
                if (verdict != ST_OK)
                begin
                    if (sup.retry_counter >= regs.retry_limit)
                        sup.over_limit = 1'b1;
                    if (sup.retry_counter != RETRY_SAT)
                        sup.retry_counter = sup.retry_counter + 1'b1;
                    r.recovery_request = sup.panel_is_on && !e.recovery_pending;
                end
                else
                begin
                    sup.retry_counter = '0;
                    sup.over_limit    = 1'b0;
                end
            end
            OP_DETECT:
                if (sup.panel_is_on && !e.recovery_pending)
                begin
                    if (det_fault)
                    begin
                        verdict            = ST_LINE;
                        r.recovery_request = 1'b1;
                        age = e.time_ms - fault_stamp[HISTORY_DEPTH-1];
                        // full history with the oldest fault inside the window: burst
                        if (fault_stamp_valid[HISTORY_DEPTH-1] && age <= regs.fault_window_ms)
                        begin
                            if (regs.window_sets_retry_over)
                                sup.over_limit = 1'b1;
                            for (int k = 0; k < HISTORY_DEPTH; k++)
                            begin
                                fault_stamp[k]       = '0;
                                fault_stamp_valid[k] = 1'b0;
                            end
                        end
                        else
                        begin
                            for (int k = HISTORY_DEPTH - 1; k > 0; k--)
                            begin
                                fault_stamp[k]       = fault_stamp[k-1];
                                fault_stamp_valid[k] = fault_stamp_valid[k-1];
                            end
                            fault_stamp[0]       = e.time_ms;
                            fault_stamp_valid[0] = 1'b1;
                        end
                    end
                    else
                        r.irq_reenable = 1'b1;
                end
            OP_LINK:
                if (sup.panel_is_on && !e.recovery_pending)
                begin
                    if (link_fault)
                    begin
                        verdict            = ST_LINE;
                        r.link_clear       = 1'b1;
                        r.recovery_request = 1'b1;
                    end
                    else
                        r.irq_reenable = 1'b1;
                end
            OP_EXT_FAIL:
                r.recovery_request = 1'b1;
            OP_ON:
                sup.panel_is_on = 1'b1;
            OP_OFF:
            begin
                sup.panel_is_on = 1'b0;
                r.backlight_off = sup.over_limit;
            end
            default:
                ;
        endcase
        r.check_result    = verdict;
        r.panel_off_event = r.recovery_request && sup.over_limit;
        r.retry_over_flag = sup.over_limit;
        r.retry_count     = sup.retry_counter;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.retry_limit             = RESET_RETRY_LIMIT;
            regs.fault_window_ms         = RESET_WINDOW_MS;
            regs.window_sets_retry_over  = 1'b1;
            regs.detect_line_present     = 1'b1;
            regs.link_error_line_present = 1'b1;
            regs.power_mode_mask         = RESET_MODE_MASK;
            sup.panel_is_on   = 1'b0;
            sup.mode_status   = ST_OK;
            sup.retry_counter = '0;
            sup.over_limit    = 1'b0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                fault_stamp[k]       = '0;
                fault_stamp_valid[k] = 1'b0;
            end
            results_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RETRY_LIMIT:      regs.retry_limit             = cfg_data[COUNT_BITS-1:0];
                    CFG_FAULT_WINDOW:     regs.fault_window_ms         = cfg_data;
                    CFG_WINDOW_SETS_OVER: regs.window_sets_retry_over  = cfg_data[0];
                    CFG_DETECT_PRESENT:   regs.detect_line_present     = cfg_data[0];
                    CFG_LINK_PRESENT:     regs.link_error_line_present = cfg_data[0];
                    CFG_POWER_MODE_MASK:  regs.power_mode_mask         = cfg_data[7:0];
                    default:              ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.check_result     = m_axis_tdata[1:0];
                seen.recovery_request = m_axis_tdata[2];
                seen.panel_off_event  = m_axis_tdata[3];
                seen.retry_over_flag  = m_axis_tdata[4];
                seen.irq_reenable     = m_axis_tdata[5];
                seen.link_clear       = m_axis_tdata[6];
                seen.backlight_off    = m_axis_tdata[7];
                seen.retry_count      = m_axis_tdata[11:8];
                if (results_due.size() == 0)
                    report_mismatch("result beat with nothing outstanding", m_axis_tdata, 0);
                else
                begin
                    due = results_due.pop_front();
                    check_field("check_result", seen.check_result, due.check_result);
                    check_field("recovery_request", seen.recovery_request,
                                due.recovery_request);
                    check_field("panel_off_event", seen.panel_off_event, due.panel_off_event);
                    check_field("retry_over_flag", seen.retry_over_flag, due.retry_over_flag);
                    check_field("irq_reenable", seen.irq_reenable, due.irq_reenable);
                    check_field("link_clear", seen.link_clear, due.link_clear);
                    check_field("backlight_off", seen.backlight_off, due.backlight_off);
                    check_field("retry_count", seen.retry_count, due.retry_count);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                ev.operation        = s_axis_tdata[2:0];
                ev.read_ok          = s_axis_tdata[3];
                ev.power_mode       = s_axis_tdata[11:4];
                ev.detect_level     = s_axis_tdata[12];
                ev.link_error_level = s_axis_tdata[13];
                ev.recovery_pending = s_axis_tdata[14];
                ev.time_ms          = s_axis_tdata[46:15];
                results_due.push_back(predict_panel_event(ev));
            end
        end
        pending_results = results_due.size();
    end

endmodule

FILE: dv/tb_panel_fault_supervisor_core.sv
// Testbench top: clock, reset, event and register stimulus, output backpressure and verdict.
module tb_panel_fault_supervisor_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    localparam int         RANDOM_ITEMS     = 1800;
    localparam int         PHASES           = 6;
    localparam int         WATCHDOG_LIMIT   = 1000;
    localparam int         HOLD_AT_BEAT     = 600;
    localparam int         HOLD_CYCLES      = 200;
    localparam int         DRAIN_CYCLES     = 8;
    localparam logic [2:0] OP_UNUSED        = 3'd7;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [7:0] RESET_MODE_MASK  = 8'h14;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [47:0]            s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index     = '0;
    logic [WINDOW_BITS-1:0] cfg_data      = '0;
    int                     fail_count;
    int                     pending_results;

    bit                     calm         = 1'b0;
    bit                     stall_active = 1'b0;
    logic [7:0]             cur_mask     = RESET_MODE_MASK;
    logic [TIME_BITS-1:0]   now_ms       = '0;
    int                     idle_cycles  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    panel_fault_supervisor_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    panel_supervisor_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Ends the run when no channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_fields(logic [2:0] op, logic rd, logic [7:0] pm, logic det,
                               logic lnk, logic pend, logic [TIME_BITS-1:0] t);
        item_t e;
        int    gap;
        e.operation        = op;
        e.read_ok          = rd;
        e.power_mode       = pm;
        e.detect_level     = det;
        e.link_error_level = lnk;
        e.recovery_pending = pend;
        e.time_ms          = t;
        // keep offering back to back while the result side is held off
        gap = (calm || stall_active) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {1'b0, e.time_ms, e.recovery_pending, e.link_error_level,
                          e.detect_level, e.power_mode, e.read_ok, e.operation};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if ($urandom_range(0, 59) == 0)
            calm = !calm;
    endtask

    task automatic send_random_event();
        int         pick;
        int         step;
        logic [2:0] op;
        logic [7:0] pm;
        pick = $urandom_range(0, 99);
        if (pick < 16)
            op = OP_MODE_CHECK;
        else if (pick < 38)
            op = OP_ON_CHECK;
        else if (pick < 62)
            op = OP_DETECT;
        else if (pick < 72)
            op = OP_LINK;
        else if (pick < 76)
            op = OP_EXT_FAIL;
        else if (pick < 90)
            op = OP_ON;
        else if (pick < 98)
            op = OP_OFF;
        else
            op = OP_UNUSED;
        pm = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            pm = pm | cur_mask;
        // mostly small steps so detect faults bunch up inside the window
        step = $urandom_range(0, 99);
        if (step < 3)
            now_ms = $urandom;
        else if (step < 6)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        else if (step < 14)
            now_ms = now_ms + $urandom_range(1, 50000);
        else
            now_ms = now_ms + $urandom_range(0, 150);
        send_fields(op, $urandom_range(0, 7) != 0, pm, $urandom_range(0, 9) >= 6,
                    1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, now_ms);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [WINDOW_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Drains the block, then rewrites every register; unused data bits carry noise.
    task automatic apply_setup(logic [3:0] limit, logic [WINDOW_BITS-1:0] window, bit sets,
                               bit det, bit lnk, logic [7:0] mask);
        logic [WINDOW_BITS-1:0] noise;
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        noise = WINDOW_BITS'($urandom);
        write_reg(CFG_RETRY_LIMIT, {noise[19:4], limit});
        write_reg(CFG_FAULT_WINDOW, window);
        write_reg(CFG_WINDOW_SETS_OVER, {noise[19:1], sets});
        write_reg(CFG_UNUSED_INDEX, noise);
        write_reg(CFG_DETECT_PRESENT, {noise[18:0], det});
        write_reg(CFG_LINK_PRESENT, {noise[17:0], lnk});
        write_reg(CFG_POWER_MODE_MASK, {noise[19:8], mask});
        cfg_valid <= 1'b0;
        cur_mask = mask;
    endtask

    // Result side: random stalls per beat, plus one long hold-off to back up the input.
    initial
    begin
        int beats;
        int gap;
        beats = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (beats == HOLD_AT_BEAT)
            begin
                stall_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_active = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            beats++;
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass on reset settings: limit 3, window 10000, mask 0x14
        send_fields(OP_MODE_CHECK, 1'b0, 8'h14, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_MODE_CHECK, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_MODE_CHECK, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0);
        send_fields(OP_ON,         1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_MODE_CHECK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        // failed checks walk the counter past the limit
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0);
        send_fields(OP_OFF,        1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_ON,         1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_EXT_FAIL,   1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 32'd0);
        send_fields(OP_ON_CHECK,   1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_LINK,       1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0);
        send_fields(OP_LINK,       1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        send_fields(OP_LINK,       1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        // four faults across the time wrap, fifth exactly one window after the oldest
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_F000);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'hFFFF_F800);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0100);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0200);
        send_fields(OP_DETECT,     1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_1710);
        send_fields(OP_UNUSED,     1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       apply_setup(4'd0, '0, 1'b0, 1'b0, 1'b0, 8'h00);
                2:       apply_setup(4'd15, '1, 1'b1, 1'b1, 1'b1, 8'hFF);
                default: apply_setup(4'($urandom_range(0, 15)),
                                     WINDOW_BITS'($urandom_range(0, 20000)),
                                     1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                                     1'($urandom_range(0, 1)), 8'($urandom));
            endcase
            repeat (RANDOM_ITEMS / PHASES) send_random_event();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
